>>> rtl/core/v3a_pkg.sv
// shared types, widths, codes and helpers of the 3d vector unit
package v3a_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int LANES = 3;
   localparam int PROD_BITS = 2 * WORD_BITS + 2;
   localparam int SUM_BITS = 2 * WORD_BITS + 4;
   localparam int SQ_BITS = 2 * WORD_BITS;
   localparam int ROOT_BITS = WORD_BITS;
   localparam int SQRT_REM_BITS = 2 * WORD_BITS + 2;
   localparam int QUO_BITS = FRAC_BITS + 1;
   localparam int DVD_BITS = WORD_BITS + FRAC_BITS;
   localparam int DIV_REM_BITS = DVD_BITS + 1;

   typedef enum logic [2:0] {
      CMD_ADD,
      CMD_SUB,
      CMD_SCALE,
      CMD_DOT,
      CMD_CROSS,
      CMD_MAG,
      CMD_NORM,
      CMD_DIST
   } cmd_type;

   localparam logic [1:0] STAT_OK = 2'd0;
   localparam logic [1:0] STAT_SAT = 2'd1;
   localparam logic [1:0] STAT_ZERO = 2'd2;

   typedef logic signed [WORD_BITS-1:0] word_type;

   typedef struct packed {
      logic signed [PROD_BITS-1:0] p0;
      logic signed [PROD_BITS-1:0] p1;
      logic signed [WORD_BITS:0] dsum;
      logic [WORD_BITS-1:0] absv;
      logic neg;
   } lane_out_type;

   typedef struct packed {
      logic valid;
      cmd_type cmd;
      logic [LANES-1:0][WORD_BITS-1:0] r;
      logic [WORD_BITS-1:0] sc;
      logic flag;
      logic big;
      logic [LANES-1:0][WORD_BITS-1:0] absv;
      logic [LANES-1:0] neg;
   } side_type;

   typedef struct packed {
      logic valid;
      cmd_type cmd;
      logic [LANES-1:0][WORD_BITS-1:0] r;
      logic [WORD_BITS-1:0] sc;
      logic flag;
      logic nzero;
      logic [LANES-1:0] neg;
   } post_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] val;
      logic ovf;
   } sat_type;

   localparam logic signed [SUM_BITS-1:0] SAT_HI =
      {{(SUM_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] SAT_LO = ~SAT_HI;

   // clamp a wide signed value to the word range
   function automatic sat_type sat_word(input logic signed [SUM_BITS-1:0] v);
      sat_type res;
      if (v > SAT_HI) begin
         res.val = SAT_HI[WORD_BITS-1:0];
         res.ovf = 1'b1;
      end else if (v < SAT_LO) begin
         res.val = SAT_LO[WORD_BITS-1:0];
         res.ovf = 1'b1;
      end else begin
         res.val = v[WORD_BITS-1:0];
         res.ovf = 1'b0;
      end
      return res;
   endfunction

endpackage

>>> rtl/core/vector3_alu.sv
// top level of the pipelined 3d vector unit
//
//  channel  direction  handshake            word
//  req      in         req_valid/req_stall  cmd, a, b, factor
//  rsp      out        rsp_valid/rsp_stall  rx, ry, rz, scalar_out, status
//
// one word accepted per cycle while the pipe is not stalled; stages: operand register, multiply,
// merge, 32 square-root stages, 17 divider stages, output register
// the square-root and divider pipelines set the latency
// synchronous reset clears only the valid bits along the pipe
// the whole pipe moves when the output register is empty or being taken,
// so a waiting result holds everything behind it
module vector3_alu (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [2:0] req_cmd,
   input  v3a_pkg::word_type req_ax,
   input  v3a_pkg::word_type req_ay,
   input  v3a_pkg::word_type req_az,
   input  v3a_pkg::word_type req_bx,
   input  v3a_pkg::word_type req_by_comp,
   input  v3a_pkg::word_type req_bz,
   input  v3a_pkg::word_type req_factor,
   output logic rsp_valid,
   input  logic rsp_stall,
   output v3a_pkg::word_type rsp_rx,
   output v3a_pkg::word_type rsp_ry,
   output v3a_pkg::word_type rsp_rz,
   output v3a_pkg::word_type rsp_scalar_out,
   output logic [1:0] rsp_status
);
   import v3a_pkg::*;

   logic en;
   cmd_type cmd;
   logic v1_ff, v2_ff;
   cmd_type cmd1_ff, cmd2_ff;
   lane_out_type lane_out [LANES];
   side_type side;
   logic [SQ_BITS-1:0] sq;
   logic [ROOT_BITS-1:0] root;
   side_type line_a_ff [ROOT_BITS];
   post_type line_b_ff [QUO_BITS];
   post_type post_in;
   side_type tail_a;
   post_type tail_b;
   logic [QUO_BITS-1:0] quo [LANES];
   logic rsp_valid_ff;
   logic [LANES-1:0][WORD_BITS-1:0] r_in, r_ff;
   logic [WORD_BITS-1:0] sc_in, sc_ff;
   logic [1:0] status_in, status_ff;

   // global advance: output free or leaving this cycle
   assign en = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;
   assign cmd = cmd_type'(req_cmd);

   // valid and command follow the lane operand and product stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cmd1_ff <= cmd;
         cmd2_ff <= cmd1_ff;
      end
   end

   // lanes x, y, z; the cross operands are wired per lane
   v3a_lane u_lane_x (
      .clock(clock), .en(en), .cmd(cmd), .a(req_ax), .b(req_bx), .factor(req_factor),
      .c0a(req_ay), .c0b(req_bz), .c1a(req_az), .c1b(req_by_comp),
      .lane_out(lane_out[0])
   );
   v3a_lane u_lane_y (
      .clock(clock), .en(en), .cmd(cmd), .a(req_ay), .b(req_by_comp), .factor(req_factor),
      .c0a(req_az), .c0b(req_bx), .c1a(req_ax), .c1b(req_bz),
      .lane_out(lane_out[1])
   );
   v3a_lane u_lane_z (
      .clock(clock), .en(en), .cmd(cmd), .a(req_az), .b(req_bz), .factor(req_factor),
      .c0a(req_ax), .c0b(req_by_comp), .c1a(req_ay), .c1b(req_bx),
      .lane_out(lane_out[2])
   );

   v3a_merge u_merge (
      .clock(clock), .reset(reset), .en(en), .valid(v2_ff), .cmd(cmd2_ff),
      .lane_out(lane_out), .side(side), .sq(sq)
   );

   v3a_sqrt u_sqrt (.clock(clock), .en(en), .sq(sq), .root(root));

   // side data rides alongside the square root
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ROOT_BITS; k++) begin
            line_a_ff[k].valid <= 1'b0;
         end
      end else if (en) begin
         line_a_ff[0] <= side;
         for (int k = 1; k < ROOT_BITS; k++) begin
            line_a_ff[k] <= line_a_ff[k-1];
         end
      end
   end

   assign tail_a = line_a_ff[ROOT_BITS-1];

   // magnitude and distance finish here, normalize goes on to the dividers
   always_comb begin
      post_in.valid = tail_a.valid;
      post_in.cmd = tail_a.cmd;
      post_in.r = tail_a.r;
      post_in.sc = tail_a.sc;
      post_in.flag = tail_a.flag;
      post_in.nzero = (root == '0);
      post_in.neg = tail_a.neg;
      if (tail_a.cmd == CMD_MAG || tail_a.cmd == CMD_DIST) begin
         // a component of magnitude 2^31 or more always overflows
         if (tail_a.big || root[ROOT_BITS-1]) begin
            post_in.sc = SAT_HI[WORD_BITS-1:0];
            post_in.flag = 1'b1;
         end else begin
            post_in.sc = root;
         end
      end
   end

   for (genvar i = 0; i < LANES; i++) begin : g_div
      v3a_div u_div (
         .clock(clock), .en(en),
         .dividend({tail_a.absv[i], {FRAC_BITS{1'b0}}}),
         .divisor(root), .quo(quo[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < QUO_BITS; k++) begin
            line_b_ff[k].valid <= 1'b0;
         end
      end else if (en) begin
         line_b_ff[0] <= post_in;
         for (int k = 1; k < QUO_BITS; k++) begin
            line_b_ff[k] <= line_b_ff[k-1];
         end
      end
   end

   assign tail_b = line_b_ff[QUO_BITS-1];

   // final select; a normalized component is at most one, never saturates
   always_comb begin
      r_in = tail_b.r;
      sc_in = tail_b.sc;
      status_in = tail_b.flag ? STAT_SAT : STAT_OK;
      if (tail_b.cmd == CMD_NORM) begin
         sc_in = '0;
         if (tail_b.nzero) begin
            r_in = '0;
            status_in = STAT_ZERO;
         end else begin
            status_in = STAT_OK;
            for (int i = 0; i < LANES; i++) begin
               r_in[i] = tail_b.neg[i] ? -WORD_BITS'(quo[i]) : WORD_BITS'(quo[i]);
            end
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= tail_b.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff <= r_in;
         sc_ff <= sc_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_rx = r_ff[0];
   assign rsp_ry = r_ff[1];
   assign rsp_rz = r_ff[2];
   assign rsp_scalar_out = sc_ff;
   assign rsp_status = status_ff;

endmodule

>>> rtl/core/v3a_lane.sv
// one lane: operand select, add/sub and two multipliers
module v3a_lane (
   input  logic clock,
   input  logic en,
   input  v3a_pkg::cmd_type cmd,
   input  v3a_pkg::word_type a,
   input  v3a_pkg::word_type b,
   input  v3a_pkg::word_type factor,
   input  v3a_pkg::word_type c0a,
   input  v3a_pkg::word_type c0b,
   input  v3a_pkg::word_type c1a,
   input  v3a_pkg::word_type c1b,
   output v3a_pkg::lane_out_type lane_out
);
   import v3a_pkg::*;

   logic signed [WORD_BITS:0] ae, be, dsum_in, sqv;
   logic [WORD_BITS:0] mag;
   logic signed [WORD_BITS:0] m0a_in, m0b_in, m1a_in, m1b_in, absop;
   logic signed [WORD_BITS:0] m0a_ff, m0b_ff, m1a_ff, m1b_ff, dsum_ff;
   logic [WORD_BITS-1:0] absv_ff;
   logic neg_ff;

   always_comb begin
      ae = (WORD_BITS+1)'(a);
      be = (WORD_BITS+1)'(b);
      case (cmd)
         CMD_SUB:  dsum_in = ae - be;
         CMD_DIST: dsum_in = be - ae;
         default:  dsum_in = ae + be;
      endcase
      sqv = (cmd == CMD_DIST) ? be - ae : ae;
      mag = sqv[WORD_BITS] ? unsigned'(-sqv) : unsigned'(sqv);
      absop = $signed({1'b0, mag[WORD_BITS-1:0]});
      m0a_in = '0;
      m0b_in = '0;
      m1a_in = '0;
      m1b_in = '0;
      case (cmd)
         CMD_SCALE: begin
            m0a_in = ae;
            m0b_in = (WORD_BITS+1)'(factor);
         end
         CMD_DOT: begin
            m0a_in = ae;
            m0b_in = be;
         end
         CMD_CROSS: begin
            m0a_in = (WORD_BITS+1)'(c0a);
            m0b_in = (WORD_BITS+1)'(c0b);
            m1a_in = (WORD_BITS+1)'(c1a);
            m1b_in = (WORD_BITS+1)'(c1b);
         end
         CMD_MAG, CMD_NORM, CMD_DIST: begin
            m0a_in = absop;
            m0b_in = absop;
         end
         default: begin
            m0a_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m0a_ff <= m0a_in;
         m0b_ff <= m0b_in;
         m1a_ff <= m1a_in;
         m1b_ff <= m1b_in;
         dsum_ff <= dsum_in;
         absv_ff <= mag[WORD_BITS-1:0];
         neg_ff <= sqv[WORD_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_out.p0 <= m0a_ff * m0b_ff;
         lane_out.p1 <= m1a_ff * m1b_ff;
         lane_out.dsum <= dsum_ff;
         lane_out.absv <= absv_ff;
         lane_out.neg <= neg_ff;
      end
   end

endmodule

>>> rtl/core/v3a_merge.sv
// merge stage: combines lane products, saturates, forms sum of squares
module v3a_merge (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic valid,
   input  v3a_pkg::cmd_type cmd,
   input  v3a_pkg::lane_out_type lane_out [v3a_pkg::LANES],
   output v3a_pkg::side_type side,
   output logic [v3a_pkg::SQ_BITS-1:0] sq
);
   import v3a_pkg::*;

   side_type side_in;
   logic signed [SUM_BITS-1:0] tot, t;
   sat_type s;

   always_comb begin
      side_in = '0;
      side_in.valid = valid;
      side_in.cmd = cmd;
      tot = '0;
      for (int i = 0; i < LANES; i++) begin
         tot = tot + SUM_BITS'(lane_out[i].p0);
         side_in.absv[i] = lane_out[i].absv;
         side_in.neg[i] = lane_out[i].neg;
         side_in.big = side_in.big | lane_out[i].absv[WORD_BITS-1];
         case (cmd)
            CMD_ADD, CMD_SUB: t = SUM_BITS'(lane_out[i].dsum);
            CMD_SCALE:        t = SUM_BITS'(lane_out[i].p0) >>> FRAC_BITS;
            CMD_CROSS:
               t = (SUM_BITS'(lane_out[i].p0) - SUM_BITS'(lane_out[i].p1)) >>> FRAC_BITS;
            default:          t = '0;
         endcase
         s = sat_word(t);
         side_in.r[i] = s.val;
         side_in.flag = side_in.flag | s.ovf;
      end
      s = sat_word(tot >>> FRAC_BITS);
      if (cmd == CMD_DOT) begin
         side_in.sc = s.val;
         side_in.flag = s.ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side.valid <= 1'b0;
      end else if (en) begin
         side <= side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq <= tot[SQ_BITS-1:0];
      end
   end

endmodule

>>> rtl/core/v3a_sqrt.sv
// pipelined integer square root, one root bit per stage
module v3a_sqrt (
   input  logic clock,
   input  logic en,
   input  logic [v3a_pkg::SQ_BITS-1:0] sq,
   output logic [v3a_pkg::ROOT_BITS-1:0] root
);
   import v3a_pkg::*;

   logic [SQRT_REM_BITS-1:0] rem_ff [ROOT_BITS];
   logic [ROOT_BITS-1:0] root_ff [ROOT_BITS];

   for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
      localparam int J = ROOT_BITS - 1 - k;
      logic [SQRT_REM_BITS-1:0] rem_cur, trial, rem_in;
      logic [ROOT_BITS-1:0] root_cur, root_in;
      if (k == 0) begin : g_first
         assign rem_cur = SQRT_REM_BITS'(sq);
         assign root_cur = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[k-1];
         assign root_cur = root_ff[k-1];
      end
      assign trial = (SQRT_REM_BITS'(root_cur) << (J + 1)) |
                     (SQRT_REM_BITS'(1) << (2 * J));
      always_comb begin
         if (rem_cur >= trial) begin
            rem_in = rem_cur - trial;
            root_in = root_cur | (ROOT_BITS'(1) << J);
         end else begin
            rem_in = rem_cur;
            root_in = root_cur;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            root_ff[k] <= root_in;
         end
      end
   end

   assign root = root_ff[ROOT_BITS-1];

endmodule

>>> rtl/core/v3a_div.sv
// pipelined restoring divider for normalize, one quotient bit per stage
module v3a_div (
   input  logic clock,
   input  logic en,
   input  logic [v3a_pkg::DVD_BITS-1:0] dividend,
   input  logic [v3a_pkg::ROOT_BITS-1:0] divisor,
   output logic [v3a_pkg::QUO_BITS-1:0] quo
);
   import v3a_pkg::*;

   logic [DIV_REM_BITS-1:0] rem_ff [QUO_BITS];
   logic [ROOT_BITS-1:0] dvs_ff [QUO_BITS];
   logic [QUO_BITS-1:0] quo_ff [QUO_BITS];

   for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
      localparam int J = QUO_BITS - 1 - k;
      logic [DIV_REM_BITS-1:0] rem_cur, cmp, rem_in;
      logic [ROOT_BITS-1:0] dvs_cur;
      logic [QUO_BITS-1:0] quo_cur, quo_in;
      if (k == 0) begin : g_first
         assign rem_cur = DIV_REM_BITS'(dividend);
         assign dvs_cur = divisor;
         assign quo_cur = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[k-1];
         assign dvs_cur = dvs_ff[k-1];
         assign quo_cur = quo_ff[k-1];
      end
      assign cmp = DIV_REM_BITS'(dvs_cur) << J;
      always_comb begin
         if (rem_cur >= cmp) begin
            rem_in = rem_cur - cmp;
            quo_in = quo_cur | (QUO_BITS'(1) << J);
         end else begin
            rem_in = rem_cur;
            quo_in = quo_cur;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            dvs_ff[k] <= dvs_cur;
            quo_ff[k] <= quo_in;
         end
      end
   end

   assign quo = quo_ff[QUO_BITS-1];

endmodule
